// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Depends on nothing; the includer supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on the rising clock, off while reset is low.
`define ASSERT_SYNC(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Concurrent assertion that also holds while reset is applied.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== src/dlsq_pkg.sv =====
// Shared types and constants for the dual line sensor qualifier.
// No dependencies; imported by the lane, the top level and the checker.
`default_nettype none

package dlsq_pkg;

  localparam int LEVEL_W    = 10;
  localparam int MAJ_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int HISTORY_DEPTH_DEF = 3;
  localparam int ADC_BITS_DEF      = 10;

  localparam logic               ANALOG_MODE_RST   = 1'b0;
  localparam logic               BLACK_IS_HIGH_RST = 1'b1;
  localparam logic [LEVEL_W-1:0] THRESHOLD_RST     = LEVEL_W'(512);
  localparam logic [LEVEL_W-1:0] BAND_RST          = LEVEL_W'(32);
  localparam logic [MAJ_W-1:0]   MAJORITY_RST      = MAJ_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ANALOG_MODE     = 3'd0,
    CFG_BLACK_IS_HIGH   = 3'd1,
    CFG_BLACK_THRESHOLD = 3'd2,
    CFG_HYSTERESIS_BAND = 3'd3,
    CFG_VOTE_MAJORITY   = 3'd4
  } cfg_reg_t;

  // Settings and sequencing handed from the top level to each lane.
  typedef struct packed {
    logic               analog_mode;
    logic               black_is_high;
    logic [LEVEL_W-1:0] threshold;
    logic [LEVEL_W-1:0] band;
    logic [MAJ_W-1:0]   majority;
    logic               voting;
    logic               advance;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ===== src/dlsq_lane.sv =====
// One sensor channel: level mapping, hysteresis comparator, vote history.
// Depends on dlsq_pkg for the lane control struct and field widths.
`default_nettype none

module dlsq_lane import dlsq_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int ADC_BITS      = ADC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lane_ctrl_t         ctrl,
  input  logic [LEVEL_W-1:0] raw,
  input  logic               read_ok,
  output logic [LEVEL_W-1:0] level,
  output logic               black
);

  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  logic                     cmp_r;
  logic                     cmp_nxt;
  logic [HISTORY_DEPTH-1:0] hist_r;
  logic [HISTORY_DEPTH-1:0] hist_nxt;
  logic [LEVEL_W-1:0]       adc_mask;
  logic [LEVEL_W-1:0]       raw_m;
  logic                     pin_high;
  logic [LEVEL_W:0]         upper;
  logic [LEVEL_W:0]         lower;
  logic [LEVEL_W:0]         value;
  logic                     fresh;
  logic [CNT_W-1:0]         ones;
  logic [MAJ_W:0]           ones_ext;

  always_comb begin
    for (int i = 0; i < LEVEL_W; i++) begin
      adc_mask[i] = (i < ADC_BITS);
    end
  end

  assign raw_m    = raw & adc_mask;
  assign pin_high = (raw_m != '0);
  assign value    = {1'b0, raw_m};

  // Band edges; the lower edge floors at zero.
  assign upper = {1'b0, ctrl.threshold} + {1'b0, ctrl.band};
  assign lower = (ctrl.threshold > ctrl.band) ?
                 {1'b0, ctrl.threshold - ctrl.band} : '0;

  always_comb begin
    if (ctrl.black_is_high) begin
      cmp_nxt = cmp_r ? (value >= lower) : (value >= upper);
    end else begin
      cmp_nxt = cmp_r ? (value <= upper) : (value <= lower);
    end
  end

  always_comb begin
    if (ctrl.analog_mode) begin
      level = raw_m;
      fresh = read_ok & cmp_nxt;
    end else begin
      level = {{(LEVEL_W-1){1'b0}}, pin_high};
      fresh = (pin_high == ctrl.black_is_high);
    end
  end

  assign hist_nxt = HISTORY_DEPTH'({hist_r, fresh});

  always_comb begin
    ones = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      ones = ones + CNT_W'(hist_nxt[i]);
    end
  end

  assign ones_ext = (MAJ_W+1)'(ones);
  assign black    = ctrl.voting ? (ones_ext >= {1'b0, ctrl.majority}) : fresh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_r  <= 1'b0;
      hist_r <= '0;
    end else if (ctrl.advance) begin
      hist_r <= hist_nxt;
      // hold the comparator on invalid analog reads and in digital mode
      if (ctrl.analog_mode && read_ok) begin
        cmp_r <= cmp_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/dual_line_sensor_qualifier.sv =====
// Top level: configuration registers, warmup counter, two sensor lanes and
// the output register that merges the lane results. Depends on dlsq_pkg, dlsq_lane.
//
//   channel  direction  handshake              payload
//   in_      sink       in_valid / in_ready    left_raw, right_raw, read_ok
//   out_     source     out_valid / out_ready  levels, sample_valid, blacks
//   cfg_     sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample per cycle unless stalled; results show the cycle after their transfer.
// The lanes and the output register form a single stage, so a new sample is
// taken whenever the output register is empty or is drained in that cycle.
// Synchronous active-low reset clears settings to defaults, the histories,
// the warmup count and the comparator states. cfg_ready is always high.
`default_nettype none

module dual_line_sensor_qualifier import dlsq_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int ADC_BITS      = ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [LEVEL_W-1:0]    in_left_raw,
  input  logic [LEVEL_W-1:0]    in_right_raw,
  input  logic                  in_read_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LEVEL_W-1:0]    out_left_level,
  output logic [LEVEL_W-1:0]    out_right_level,
  output logic                  out_sample_valid,
  output logic                  out_left_black,
  output logic                  out_right_black,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int WARM_W = $clog2(HISTORY_DEPTH + 1);

  logic               analog_mode_r;
  logic               black_is_high_r;
  logic [LEVEL_W-1:0] threshold_r;
  logic [LEVEL_W-1:0] band_r;
  logic [MAJ_W-1:0]   majority_r;
  logic [WARM_W-1:0]  warm_r;
  logic [WARM_W-1:0]  warm_nxt;
  logic               accept;
  lane_ctrl_t         ctrl;
  logic [LEVEL_W-1:0] left_level;
  logic [LEVEL_W-1:0] right_level;
  logic               left_black;
  logic               right_black;

  logic               out_valid_r;
  logic [LEVEL_W-1:0] left_level_r;
  logic [LEVEL_W-1:0] right_level_r;
  logic               sample_valid_r;
  logic               left_black_r;
  logic               right_black_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      analog_mode_r   <= ANALOG_MODE_RST;
      black_is_high_r <= BLACK_IS_HIGH_RST;
      threshold_r     <= THRESHOLD_RST;
      band_r          <= BAND_RST;
      majority_r      <= MAJORITY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ANALOG_MODE:     analog_mode_r   <= cfg_data[0];
        CFG_BLACK_IS_HIGH:   black_is_high_r <= cfg_data[0];
        CFG_BLACK_THRESHOLD: threshold_r     <= cfg_data;
        CFG_HYSTERESIS_BAND: band_r          <= cfg_data;
        CFG_VOTE_MAJORITY:   majority_r      <= cfg_data[MAJ_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturating warmup count; the sample that brings it to the depth votes.
  assign warm_nxt = (warm_r == WARM_W'(HISTORY_DEPTH)) ? warm_r : warm_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= '0;
    end else if (accept) begin
      warm_r <= warm_nxt;
    end
  end

  assign ctrl.analog_mode   = analog_mode_r;
  assign ctrl.black_is_high = black_is_high_r;
  assign ctrl.threshold     = threshold_r;
  assign ctrl.band          = band_r;
  assign ctrl.majority      = majority_r;
  assign ctrl.voting        = (warm_r >= WARM_W'(HISTORY_DEPTH - 1));
  assign ctrl.advance       = accept;

  dlsq_lane #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .ADC_BITS     (ADC_BITS)
  ) u_lane_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .raw    (in_left_raw),
    .read_ok(in_read_ok),
    .level  (left_level),
    .black  (left_black)
  );

  dlsq_lane #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .ADC_BITS     (ADC_BITS)
  ) u_lane_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .raw    (in_right_raw),
    .read_ok(in_read_ok),
    .level  (right_level),
    .black  (right_black)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Merge both lanes into one result word; hold while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      left_level_r   <= left_level;
      right_level_r  <= right_level;
      sample_valid_r <= !analog_mode_r || in_read_ok;
      left_black_r   <= left_black;
      right_black_r  <= right_black;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_left_level   = left_level_r;
  assign out_right_level  = right_level_r;
  assign out_sample_valid = sample_valid_r;
  assign out_left_black   = left_black_r;
  assign out_right_black  = right_black_r;

endmodule

`default_nettype wire

// ===== src/dlsq_checker.sv =====
// Port-level checks for the dual line sensor qualifier, bound to the top level.
// Depends on dlsq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dlsq_checker import dlsq_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [LEVEL_W-1:0]    in_left_raw,
  input wire logic [LEVEL_W-1:0]    in_right_raw,
  input wire logic                  in_read_ok,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [LEVEL_W-1:0]    out_left_level,
  input wire logic [LEVEL_W-1:0]    out_right_level,
  input wire logic                  out_sample_valid,
  input wire logic                  out_left_black,
  input wire logic                  out_right_black,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Every transfer in yields a result on the next cycle.
  `ASSERT_SYNC(a_accept_gives_result, clk, rst_n, (in_valid && in_ready) |=> out_valid)

  // An empty output register never blocks the input.
  `ASSERT_SYNC(a_empty_takes_input, clk, rst_n, !out_valid |-> in_ready)

  // A stalled result stays offered.
  `ASSERT_SYNC(a_out_valid_holds, clk, rst_n, (out_valid && !out_ready) |=> out_valid)

  // A stalled result keeps its payload.
  `ASSERT_SYNC(a_out_payload_holds, clk, rst_n,
    (out_valid && !out_ready) |=> ($stable(out_left_level) && $stable(out_right_level) &&
    $stable(out_sample_valid) && $stable(out_left_black) && $stable(out_right_black)))

endmodule

bind dual_line_sensor_qualifier dlsq_checker u_dlsq_checker (.*);

`default_nettype wire
